/* rtl/core/msic_pkg.sv */
`default_nettype none

package msic_pkg;

    localparam int VAL_W = 32;
    localparam int INV_W = 11;
    localparam int CMP_W = 9;

    // positions and lengths within the store, sized for the largest array (64)
    localparam int POS_W = 7;

    localparam int STACK_DEPTH = 8;
    localparam int STACK_AW    = 3;
    localparam int SP_W        = 4;

    typedef struct packed {
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] mid;
        logic [POS_W-1:0] hi;
    } msic_range_t;

    typedef struct packed {
        logic        valid;
        msic_range_t range;
    } msic_merge_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/merge_sort_inversion_counter_top.sv */
// load: a value is taken each time start is high while idle; busy stays low until the flagged last value is taken
// sort: each merge copies its range from the store into scratch, then alternates read and compare-write states
//   on the shared comparator; the split sequencer pushes and pops its range stack between merges
// emission: one sorted value per cycle, the strobe registered together with each store read
// next array accepted from the cycle that carries the last result; the receiver cannot stall
// reset (rst_n, async, active low) clears control, counts and split stack; stores hold junk
`default_nettype none

module merge_sort_inversion_counter_top
    import msic_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [VAL_W-1:0] value,
    input  wire logic                    is_last,
    output logic                         busy,
    output logic                         result_strobe,
    output logic signed [VAL_W-1:0]      sorted_value,
    output logic [INV_W-1:0]             inversion_total,
    output logic [CMP_W-1:0]             comparison_total,
    output logic                         final_res
);

    localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_COPY,
        ST_CDRAIN,
        ST_MRD,
        ST_MCMP,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [POS_W-1:0]   count_reg;
    logic [INV_W-1:0]   inv_reg;
    logic [CMP_W-1:0]   cmp_reg;
    logic [POS_W-1:0]   i_reg;
    logic [POS_W-1:0]   j_reg;
    logic [POS_W-1:0]   k_reg;
    logic [POS_W-1:0]   mid_reg;
    logic [POS_W-1:0]   hi_reg;
    logic [POS_W-1:0]   t_reg;
    logic [POS_W-1:0]   e_reg;
    logic               copy_wr_reg;
    logic [AW-1:0]      copy_wa_reg;
    logic               merge_done_reg;
    logic               strobe_reg;
    logic               final_reg;
    logic [INV_W-1:0]   inv_out_reg;
    logic [CMP_W-1:0]   cmp_out_reg;

    logic [VAL_W-1:0]   store_mem   [DEPTH];
    logic [VAL_W-1:0]   scratch_mem [DEPTH];
    logic [VAL_W-1:0]   store_rd_reg;
    logic [VAL_W-1:0]   lv_reg;
    logic [VAL_W-1:0]   uv_reg;

    logic               accept;
    logic               load_ok;
    logic [POS_W-1:0]   loaded_count_next;
    logic               sort_go;
    logic               i_ok;
    logic               j_ok;
    logic               lower_le;
    logic               take_lower;
    logic [VAL_W-1:0]   merge_val;
    logic               store_we;
    logic [AW-1:0]      store_wa;
    logic [VAL_W-1:0]   store_wd;
    logic [AW-1:0]      store_ra;
    logic               emit_last;

    msic_merge_cmd_t    merge_cmd;
    logic               sort_done;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign load_ok = (count_reg < POS_W'(MAX_ITEMS));
    assign loaded_count_next = load_ok ? count_reg + 1'b1 : count_reg;
    assign sort_go = accept && is_last;

    // shared compare unit, lower half wins ties
    assign i_ok       = (i_reg < mid_reg);
    assign j_ok       = (j_reg < hi_reg);
    assign lower_le   = ($signed(lv_reg) <= $signed(uv_reg));
    assign take_lower = i_ok && (!j_ok || lower_le);
    assign merge_val  = take_lower ? lv_reg : uv_reg;

    assign store_we = (accept && load_ok) || (state_reg == ST_MCMP);
    assign store_wa = (state_reg == ST_MCMP) ? k_reg[AW-1:0] : count_reg[AW-1:0];
    assign store_wd = (state_reg == ST_MCMP) ? merge_val : value;
    assign store_ra = (state_reg == ST_EMIT) ? e_reg[AW-1:0] : t_reg[AW-1:0];

    assign emit_last = (e_reg == count_reg - 1'b1);

    assign result_strobe    = strobe_reg;
    assign sorted_value     = store_rd_reg;
    assign final_res        = final_reg;
    assign inversion_total  = inv_out_reg;
    assign comparison_total = cmp_out_reg;

    msic_split_seq u_split_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (sort_go),
        .count      (loaded_count_next),
        .merge_done (merge_done_reg),
        .cmd        (merge_cmd),
        .sort_done  (sort_done)
    );

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_wa] <= store_wd;
        end
        store_rd_reg <= store_mem[store_ra];
    end

    always_ff @(posedge clk)
    begin
        if (copy_wr_reg)
        begin
            scratch_mem[copy_wa_reg] <= store_rd_reg;
        end
        lv_reg <= scratch_mem[i_reg[AW-1:0]];
        uv_reg <= scratch_mem[j_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            inv_reg        <= '0;
            cmp_reg        <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            mid_reg        <= '0;
            hi_reg         <= '0;
            t_reg          <= '0;
            e_reg          <= '0;
            copy_wr_reg    <= 1'b0;
            copy_wa_reg    <= '0;
            merge_done_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            final_reg      <= 1'b0;
            inv_out_reg    <= '0;
            cmp_out_reg    <= '0;
        end
        else
        begin
            copy_wr_reg    <= 1'b0;
            merge_done_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            final_reg      <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= loaded_count_next;
                        if (is_last)
                        begin
                            inv_reg   <= '0;
                            cmp_reg   <= '0;
                            state_reg <= ST_SORT;
                        end
                    end
                end
                ST_SORT:
                begin
                    if (merge_cmd.valid)
                    begin
                        t_reg     <= merge_cmd.range.lo;
                        i_reg     <= merge_cmd.range.lo;
                        k_reg     <= merge_cmd.range.lo;
                        j_reg     <= merge_cmd.range.mid;
                        mid_reg   <= merge_cmd.range.mid;
                        hi_reg    <= merge_cmd.range.hi;
                        state_reg <= ST_COPY;
                    end
                    else if (sort_done)
                    begin
                        e_reg     <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_COPY:
                begin
                    // store read lands next cycle, scratch write registered behind it
                    copy_wr_reg <= 1'b1;
                    copy_wa_reg <= t_reg[AW-1:0];
                    t_reg       <= t_reg + 1'b1;
                    if (t_reg == hi_reg - 1'b1)
                    begin
                        state_reg <= ST_CDRAIN;
                    end
                end
                ST_CDRAIN:
                begin
                    state_reg <= ST_MRD;
                end
                ST_MRD:
                begin
                    state_reg <= ST_MCMP;
                end
                ST_MCMP:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (take_lower)
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        j_reg   <= j_reg + 1'b1;
                        inv_reg <= inv_reg + INV_W'(mid_reg - i_reg);
                    end
                    if (i_ok && j_ok)
                    begin
                        cmp_reg <= cmp_reg + 1'b1;
                    end
                    if (k_reg == hi_reg - 1'b1)
                    begin
                        merge_done_reg <= 1'b1;
                        state_reg      <= ST_SORT;
                    end
                    else
                    begin
                        state_reg <= ST_MRD;
                    end
                end
                ST_EMIT:
                begin
                    strobe_reg  <= 1'b1;
                    final_reg   <= emit_last;
                    inv_out_reg <= emit_last ? inv_reg : '0;
                    cmp_out_reg <= emit_last ? cmp_reg : '0;
                    e_reg       <= e_reg + 1'b1;
                    if (emit_last)
                    begin
                        count_reg <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_final_has_strobe : assert property (@(posedge clk) disable iff (!rst_n)
        final_res |-> result_strobe)
        else $error("final_res without result strobe");

    a_counts_zero_midway : assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !final_res) |-> (inversion_total == '0 && comparison_total == '0))
        else $error("counts non-zero before the last result");

    a_emission_contiguous : assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !final_res) |=> result_strobe)
        else $error("gap in sorted output");

    a_last_starts_sort : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && is_last) |=> busy)
        else $error("last value transfer did not start the sort");
`endif

endmodule

`default_nettype wire

/* rtl/core/msic_split_seq.sv */
`default_nettype none

module msic_split_seq
    import msic_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             go,
    input  wire logic [POS_W-1:0] count,
    input  wire logic             merge_done,
    output msic_merge_cmd_t       cmd,
    output logic                  sort_done
);

    typedef enum logic [1:0] {PH_LOWER, PH_UPPER, PH_MERGE} phase_t;

    typedef struct packed {
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] len;
        phase_t           phase;
    } frame_t;

    typedef enum logic [1:0] {SQ_IDLE, SQ_STEP, SQ_WAIT} seq_state_t;

    seq_state_t        state_reg;
    frame_t            stack_reg [STACK_DEPTH];
    logic [SP_W-1:0]   sp_reg;
    msic_merge_cmd_t   cmd_reg;
    logic              done_reg;

    logic [STACK_AW-1:0] top_idx;
    logic [STACK_AW-1:0] push_idx;
    frame_t              top;
    logic [POS_W-1:0]    half;

    assign top_idx  = STACK_AW'(sp_reg - 1'b1);
    assign push_idx = sp_reg[STACK_AW-1:0];
    assign top      = stack_reg[top_idx];
    assign half     = top.len >> 1;

    assign cmd       = cmd_reg;
    assign sort_done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            sp_reg    <= '0;
            cmd_reg   <= '0;
            done_reg  <= 1'b0;
            for (int s = 0; s < STACK_DEPTH; s++)
            begin
                stack_reg[s] <= '0;
            end
        end
        else
        begin
            cmd_reg.valid <= 1'b0;
            done_reg      <= 1'b0;
            case (state_reg)
                SQ_IDLE:
                begin
                    if (go)
                    begin
                        stack_reg[0] <= '{lo: '0, len: count, phase: PH_LOWER};
                        sp_reg       <= SP_W'(1);
                        state_reg    <= SQ_STEP;
                    end
                end
                SQ_STEP:
                begin
                    if (sp_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= SQ_IDLE;
                    end
                    else if (top.len <= POS_W'(1))
                    begin
                        sp_reg <= sp_reg - 1'b1;
                    end
                    else
                    begin
                        case (top.phase)
                            PH_LOWER:
                            begin
                                stack_reg[top_idx].phase <= PH_UPPER;
                                stack_reg[push_idx] <= '{lo: top.lo, len: half,
                                                         phase: PH_LOWER};
                                sp_reg <= sp_reg + 1'b1;
                            end
                            PH_UPPER:
                            begin
                                stack_reg[top_idx].phase <= PH_MERGE;
                                stack_reg[push_idx] <= '{lo: top.lo + half,
                                                         len: top.len - half,
                                                         phase: PH_LOWER};
                                sp_reg <= sp_reg + 1'b1;
                            end
                            default:
                            begin
                                // both halves sorted: hand the range to the merge unit
                                cmd_reg.valid     <= 1'b1;
                                cmd_reg.range.lo  <= top.lo;
                                cmd_reg.range.mid <= top.lo + half;
                                cmd_reg.range.hi  <= top.lo + top.len;
                                sp_reg            <= sp_reg - 1'b1;
                                state_reg         <= SQ_WAIT;
                            end
                        endcase
                    end
                end
                SQ_WAIT:
                begin
                    if (merge_done)
                    begin
                        state_reg <= SQ_STEP;
                    end
                end
                default:
                begin
                    state_reg <= SQ_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
